FILE: design/stp_pkg.sv
// Shared types, field widths and codes for the soft timer pool.
`timescale 1ns / 1ps

package stp_pkg;

    localparam int POOL_ENTRIES_DEF = 8;

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_OBTAIN  = 3'd1,
        ACT_SET     = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_READ    = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_BUSY = 2'd2
    } status_t;

    // One request word as held in the input register.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  timer_index;
        logic [COUNT_W-1:0]  load_value;
    } stp_cmd_t;

    // One result word as produced by the timer table.
    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  granted_index;
        logic [COUNT_W-1:0]  count_value;
    } stp_res_t;

endpackage

FILE: design/stp_if.sv
// Request and response channel interfaces of the soft timer pool.
`timescale 1ns / 1ps

interface stp_req_if
    import stp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  timer_index;
    logic [COUNT_W-1:0]  load_value;

    modport source (output valid, output action, output timer_index, output load_value,
                    input ready);
    modport sink   (input valid, input action, input timer_index, input load_value,
                    output ready);
endinterface

interface stp_rsp_if
    import stp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [COUNT_W-1:0]  count_value;

    modport source (output valid, output status, output granted_index, output count_value,
                    input ready);
    modport sink   (input valid, input status, input granted_index, input count_value,
                    output ready);
endinterface

FILE: design/stp_free_find.sv
// Lowest-free-entry priority encoder over the general timer entries.
`timescale 1ns / 1ps

module stp_free_find
    import stp_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    localparam int GIDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1
)(
    input  logic [POOL_ENTRIES-1:0] busy,
    output logic                    found,
    output logic [GIDX_W-1:0]       free_idx
);

    // Scan from the top so the lowest free entry wins.
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int k = POOL_ENTRIES - 1; k >= 0; k--)
        begin
            if (!busy[k])
            begin
                found    = 1'b1;
                free_idx = GIDX_W'(k);
            end
        end
    end

endmodule

FILE: design/stp_timer_table.sv
// Timer table: busy marks, counts and the single-pass request execution.
`timescale 1ns / 1ps

module stp_timer_table
    import stp_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  stp_cmd_t cmd,
    output stp_res_t res
);

    localparam int SLOTS  = POOL_ENTRIES + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int GIDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CMP_W  = ((INDEX_W > SLOT_W) ? INDEX_W : SLOT_W) + 1;
    localparam int RESERVED = POOL_ENTRIES;

    logic [SLOTS-1:0]   busy_reg;
    logic [SLOTS-1:0]   busy_next;
    logic [COUNT_W-1:0] counts_reg  [SLOTS];
    logic [COUNT_W-1:0] counts_next [SLOTS];

    logic                      found;
    logic [GIDX_W-1:0]         free_idx;
    logic [GIDX_W+INDEX_W-1:0] free_ext;
    logic [CMP_W-1:0]          idx_ext;
    logic                      in_range;
    logic [SLOT_W-1:0]         slot;
    logic [SLOT_W-1:0]         free_slot;

    stp_free_find #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_free_find (
        .busy     (busy_reg[POOL_ENTRIES-1:0]),
        .found    (found),
        .free_idx (free_idx)
    );

    assign idx_ext   = CMP_W'(cmd.timer_index);
    assign in_range  = idx_ext < CMP_W'(SLOTS);
    assign slot      = idx_ext[SLOT_W-1:0];
    assign free_slot = SLOT_W'(free_idx);
    // Granted index is carried at the port width, high bits dropped.
    assign free_ext  = {{INDEX_W{1'b0}}, free_idx};

    always_comb
    begin
        busy_next         = busy_reg;
        counts_next       = counts_reg;
        res.status        = ST_OK;
        res.granted_index = '0;
        res.count_value   = '0;
        unique case (cmd.action)
            ACT_TICK:
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (busy_reg[k])
                    begin
                        counts_next[k] = counts_reg[k] + COUNT_W'(1);
                    end
                end
            end
            ACT_OBTAIN:
            begin
                if (found)
                begin
                    busy_next[free_slot]   = 1'b1;
                    counts_next[free_slot] = cmd.load_value;
                    res.granted_index      = free_ext[INDEX_W-1:0];
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            ACT_SET:
            begin
                if (in_range && busy_reg[slot])
                begin
                    counts_next[slot] = cmd.load_value;
                end
                else
                begin
                    res.status = ST_NOT_BUSY;
                end
            end
            ACT_RELEASE:
            begin
                if (in_range)
                begin
                    busy_next[slot]   = 1'b0;
                    counts_next[slot] = '0;
                end
            end
            ACT_READ:
            begin
                if (in_range)
                begin
                    res.count_value = counts_reg[slot];
                end
            end
            default:
            begin
                // Unknown request: leave the table alone, answer all zero.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= {1'b1, {POOL_ENTRIES{1'b0}}};
            for (int k = 0; k < SLOTS; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            busy_reg   <= busy_next;
            counts_reg <= counts_next;
        end
    end

    // Hold the table when no request executes.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(busy_reg))
        else $error("busy marks changed without a request");

    // The reserved entry is never granted, so once released it stays free.
    a_reserved_stays_free: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg[RESERVED] |=> !busy_reg[RESERVED])
        else $error("reserved entry became busy again");

    // A tick advances counts only and leaves every busy mark as it was.
    a_tick_keeps_marks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.action == ACT_TICK |=> busy_reg == $past(busy_reg))
        else $error("tick changed the busy marks");

endmodule

FILE: design/soft_timer_pool.sv
// Soft timer pool top level: input register, timer table and result register.
// Path: an accepted word waits in the input register; when it advances, the table executes it
// and its result is loaded into the result register, from which the sink takes it.
// Throughput: one word per cycle while the sink is ready; the table executes each request in one pass.
// Stalls: the result register holds while the sink is not ready; the input register then fills.
// Reset: all general entries free with count zero, reserved entry busy, both stages empty.
`timescale 1ns / 1ps

module soft_timer_pool
    import stp_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    stp_req_if.sink    req,
    stp_rsp_if.source  rsp
);

    // Input register stage.
    logic     in_valid_reg;
    logic     in_valid_next;
    stp_cmd_t in_word_reg;

    // Result register stage.
    logic     out_valid_reg;
    logic     out_valid_next;
    stp_res_t out_word_reg;

    stp_res_t table_res;
    logic     advance;
    logic     in_ready;

    // Advance the held request into the result register when that register
    // is empty or its word is being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    // Take a new word whenever the input register is empty or draining.
    assign in_ready = !in_valid_reg || advance;

    assign req.ready = in_ready;

    stp_timer_table #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cmd   (in_word_reg),
        .res   (table_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = req.valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load the request word on accept, the result on advance.
    always_ff @(posedge clk)
    begin
        if (in_ready && req.valid)
        begin
            in_word_reg.action      <= req.action;
            in_word_reg.timer_index <= req.timer_index;
            in_word_reg.load_value  <= req.load_value;
        end
        if (advance)
        begin
            out_word_reg <= table_res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_word_reg.status;
    assign rsp.granted_index = out_word_reg.granted_index;
    assign rsp.count_value   = out_word_reg.count_value;

    // A held request stays put while the result register is stalled.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !rsp.ready |=> in_valid_reg)
        else $error("held request word lost under stall");

    // The input side backs off only when both stages are full and stalled.
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (in_valid_reg && out_valid_reg && !rsp.ready))
        else $error("input not ready without a full stalled pipeline");

    // A pool-full answer never carries a granted entry.
    a_full_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.status == ST_FULL |-> out_word_reg.granted_index == '0)
        else $error("pool-full result with nonzero granted index");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the soft timer pool: predicts each result word and compares it.
`timescale 1ns / 1ps

module testbench
    import stp_pkg::*;
;

    localparam int POOL  = POOL_ENTRIES_DEF;
    localparam int SLOTS = POOL + 1;      // general entries plus the reserved one
    localparam int RSVD  = POOL;          // index of the reserved entry
    localparam int RANDOM_WORDS = 1150;
    localparam int DRAIN_CYCLES = 10;     // extra wait for stray replies after the queue empties
    localparam int HOLD_CYCLES  = 80;     // long back-pressure stretch on the result side

    // Track the timer table, queue the reply each request should produce and
    // compare the replies as they leave the block, oldest first.
    class timer_pool_scoreboard;
        bit              busy[SLOTS];
        logic [15:0]     counts[SLOTS];
        stp_res_t        pending_replies[$];
        int              errors;
        int              replies_seen;
        int              requests_seen;
        int              action_seen[8];
        int              full_refusals;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                busy[k]   = 1'b0;
                counts[k] = '0;
            end
            busy[RSVD] = 1'b1;
        endfunction

        // Apply one request to the table and return the reply it causes.
        function stp_res_t run_request(logic [2:0] act, logic [3:0] idx, logic [15:0] start);
            stp_res_t reply;
            bit       in_range;
            in_range = (idx < SLOTS);
            reply.status        = ST_OK;
            reply.granted_index = '0;
            reply.count_value   = '0;
            case (act)
                ACT_TICK:
                begin
                    for (int k = 0; k < SLOTS; k++)
                        if (busy[k])
                            counts[k] = counts[k] + 16'd1;
                end
                ACT_OBTAIN:
                begin
                    reply.status = ST_FULL;
                    for (int k = 0; k < POOL; k++)
                    begin
                        if (!busy[k] && reply.status == ST_FULL)
                        begin
                            busy[k]             = 1'b1;
                            counts[k]           = start;
                            reply.status        = ST_OK;
                            reply.granted_index = 4'(k);
                        end
                    end
                end
                ACT_SET:
                begin
                    if (in_range && busy[idx])
                        counts[idx] = start;
                    else
                        reply.status = ST_NOT_BUSY;
                end
                ACT_RELEASE:
                begin
                    if (in_range)
                    begin
                        busy[idx]   = 1'b0;
                        counts[idx] = '0;
                    end
                end
                ACT_READ:
                begin
                    if (in_range)
                        reply.count_value = counts[idx];
                end
                default:
                begin
                end
            endcase
            return reply;
        endfunction

        function void note_request(logic [2:0] act, logic [3:0] idx, logic [15:0] start);
            stp_res_t reply;
            reply = run_request(act, idx, start);
            requests_seen++;
            action_seen[act]++;
            if (reply.status == ST_FULL)
                full_refusals++;
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [1:0] status, logic [3:0] granted, logic [15:0] count);
            stp_res_t want;
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("reply word with no request outstanding: status %0d granted %0d count %0d",
                       status, granted, count);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (granted !== want.granted_index)
            begin
                $error("granted_index: expected %0d, got %0d", want.granted_index, granted);
                errors++;
            end
            if (count !== want.count_value)
            begin
                $error("count_value: expected %0h, got %0h", want.count_value, count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;    // when set, both sides run flat out with no gaps

    timer_pool_scoreboard board;

    stp_req_if req_ch ();
    stp_rsp_if rsp_ch ();

    soft_timer_pool #(
        .POOL_ENTRIES (POOL)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: end the run if the block ever locks up.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Observe both channels at the rising edge. A word in flight on the
    // request side cannot leave on the reply side at the same edge, so the
    // order of the two calls does not matter.
    always @(posedge clk)
    begin
        if (rst_n && board != null)
        begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.action, req_ch.timer_index, req_ch.load_value);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_reply(rsp_ch.status, rsp_ch.granted_index, rsp_ch.count_value);
        end
    end

    // Offer one request word. Called at a falling edge and returns at a
    // falling edge once the word has been taken. A gap drops valid first;
    // with no gap, valid stays high and only the payload moves on.
    task automatic send_request(input logic [2:0] act, input logic [3:0] idx,
                                input logic [15:0] start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.timer_index <= idx;
        req_ch.load_value  <= start;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Draw one random request. Most indices land on real entries; starts are
    // often near the top so that ticking wraps. Obtain and release take
    // turns dominating so the pool swings between empty and full.
    task automatic send_random_request(input int n);
        logic [2:0]  act;
        logic [3:0]  idx;
        logic [15:0] start;
        int          pick;
        int          obtain_w;
        bit [31:0]   raw;
        obtain_w = ((n / 150) % 2 == 0) ? 22 : 10;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            act = ACT_TICK;
        else if (pick < 28 + obtain_w)
            act = ACT_OBTAIN;
        else if (pick < 45 + obtain_w)
            act = ACT_SET;
        else if (pick < 76)
            act = ACT_RELEASE;
        else if (pick < 95)
            act = ACT_READ;
        else
            act = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0)
            idx = 4'($urandom_range(9, 15));
        else
            idx = 4'($urandom_range(0, RSVD));
        // keep the reserved entry busy until the closing sequence
        if (act == ACT_RELEASE && idx == RSVD)
            idx = 4'($urandom_range(0, POOL - 1));
        raw = $urandom();
        if ($urandom_range(0, 3) == 0)
            start = 16'hFFFF - 16'($urandom_range(0, 7));
        else
            start = raw[15:0];
        send_request(act, idx, start);
    endtask

    // Result side: draw a stall before each reply word, and once hold ready
    // low for a long stretch so that both stages fill and the input stalls.
    initial
    begin
        int  gap;
        bit  held_once;
        held_once    = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (!held_once && board.replies_seen >= 300)
            begin
                held_once = 1'b1;
                gap       = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed corners, random traffic, closing
    // sequence on the reserved entry, drain and verdict.
    initial
    begin
        board              = new();
        no_idle            = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = '0;
        req_ch.timer_index = '0;
        req_ch.load_value  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reserved entry ticks from reset; obtain at the top wraps.
        send_request(ACT_TICK,   4'd0,      16'h0000);
        send_request(ACT_READ,   4'(RSVD),  16'h0000);
        send_request(ACT_OBTAIN, 4'd15,     16'hFFFF);
        send_request(ACT_TICK,   4'd0,      16'h0000);
        send_request(ACT_READ,   4'd0,      16'hFFFF);
        // set on a free entry and on an index past the reserved one
        send_request(ACT_SET,     4'd1,     16'h1234);
        send_request(ACT_SET,     4'd15,    16'hFFFF);
        send_request(ACT_RELEASE, 4'd15,    16'h0000);
        send_request(ACT_READ,    4'd15,    16'h0000);
        // fill the rest of the pool, then one more obtain is refused
        for (int k = 1; k < POOL; k++)
            send_request(ACT_OBTAIN, 4'(k), 16'(k * 16'h1111));
        send_request(ACT_OBTAIN, 4'd0, 16'h5555);
        send_request(3'b111, 4'hF, 16'hFFFF);   // unknown action, all ones
        send_request(ACT_SET, 4'd0, 16'hFFFF);
        // release twice, read the cleared count, obtain reclaims the slot
        send_request(ACT_RELEASE, 4'd3, 16'h0000);
        send_request(ACT_RELEASE, 4'd3, 16'h0000);
        send_request(ACT_READ,    4'd3, 16'h0000);
        send_request(ACT_OBTAIN,  4'd0, 16'hABCD);

        // Random traffic; every hundred words, idling is switched off with a one-in-four chance.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_random_request(n);
        end
        no_idle = 1'b0;

        // Closing: wrap the reserved entry, then release it; it stops ticking
        // and a set on it is refused.
        send_request(ACT_SET,     4'(RSVD), 16'hFFFF);
        send_request(ACT_TICK,    4'd0,     16'h0000);
        send_request(ACT_READ,    4'(RSVD), 16'h0000);
        send_request(ACT_RELEASE, 4'(RSVD), 16'h0000);
        send_request(ACT_TICK,    4'd0,     16'h0000);
        send_request(ACT_READ,    4'(RSVD), 16'h0000);
        send_request(ACT_SET,     4'(RSVD), 16'h0001);
        req_ch.valid <= 1'b0;

        // Drain: wait for every queued reply, then a little longer for strays.
        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending_replies.size() != 0)
        begin
            $error("%0d reply words never arrived", board.pending_replies.size());
            board.errors++;
        end

        $display("Covered %0d requests: %0d ticks, %0d obtains (%0d refused), %0d sets,",
                 board.requests_seen, board.action_seen[ACT_TICK],
                 board.action_seen[ACT_OBTAIN], board.full_refusals,
                 board.action_seen[ACT_SET]);
        $display("  %0d releases, %0d reads, %0d unknown actions; %0d replies compared.",
                 board.action_seen[ACT_RELEASE], board.action_seen[ACT_READ],
                 board.action_seen[5] + board.action_seen[6] + board.action_seen[7],
                 board.replies_seen);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
